[rtl/dsfr_pkg.sv]
// Shared constants and types for the dual stepper frequency ramp block.
package dsfr_pkg;

  // Tick periods and counts.
  localparam int UP_PERIOD_A   = 10;
  localparam int DOWN_PERIOD_A = 10;
  localparam int UP_PERIOD_B   = 10;
  localparam int DOWN_PERIOD_B = 10;
  localparam int ENABLE_DELAY  = 40;
  localparam int LED_PERIOD    = 500;
  localparam int TOGGLE_SPAN   = 20000;
  localparam int TOGGLE_PHASE  = 19999;
  localparam int BEACON_MAX    = 20;

  // Phase counter widths, sized for the largest allowed period of each kind.
  localparam int RAMP_PH_W = 10;
  localparam int LED_PH_W  = 14;
  localparam int TOG_PH_W  = 15;

  // Ramp periods per motor, motor A at index 0.
  localparam logic [1:0][RAMP_PH_W-1:0] UP_PERIODS =
    {RAMP_PH_W'(UP_PERIOD_B), RAMP_PH_W'(UP_PERIOD_A)};
  localparam logic [1:0][RAMP_PH_W-1:0] DOWN_PERIODS =
    {RAMP_PH_W'(DOWN_PERIOD_B), RAMP_PH_W'(DOWN_PERIOD_A)};

  // Beat widths.
  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 48;
  localparam int ADDR_W   = 5;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_UP_STEP_A    = 3'd0,
    REG_DOWN_STEP_A  = 3'd1,
    REG_UP_STEP_B    = 3'd2,
    REG_DOWN_STEP_B  = 3'd3,
    REG_STEP_LIMIT_A = 3'd4,
    REG_STEP_LIMIT_B = 3'd5,
    REG_FLOOR_FREQ_A = 3'd6,
    REG_FLOOR_FREQ_B = 3'd7
  } reg_idx_t;

endpackage

[rtl/dual_stepper_frequency_ramp_top.sv]
// Top level of the dual stepper frequency ramp: tick engine, ramp logic and register file.
//
// Each input beat is a tick, a start or stop command or a no-op, and yields exactly one
// output beat that reports both motor frequencies, the ramp flags and the tick-driven
// status bits after the beat has been applied. The state and the output register
// update at the edge where the beat is accepted, so the block takes one beat per cycle
// unless the output stalls. The output register is the only buffer; s_axis_tready is
// low only while a result waits and m_axis_tready is low. Tick periods are tracked by
// small phase counters beside the 16-bit tick counter, which restart when the tick
// counter wraps. Registers must be written by the user through the APB port only while
// no beat is in flight; the block does not enforce it.
module dual_stepper_frequency_ramp_top
  import dsfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] target_freq, [16] status_acked, [23:17] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [1:0] op, [2] motor
  input  logic [S_USER_W-1:0] s_axis_tuser,
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] freq_a, [31:16] freq_b, [32] update_a, [33] update_b, [34] rising_a,
  // [35] falling_a, [36] rising_b, [37] falling_b, [38] drive_on, [39] led_lit,
  // [40] beacon, [41] enable_toggle, [47:42] zero
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers, motor A at index 0.
  logic [1:0][15:0] up_step;
  logic [1:0][15:0] down_step;
  logic [1:0][7:0]  step_limit;
  logic [1:0][15:0] floor_freq;

  // Engine state.
  logic [15:0]                tick_count;
  logic [15:0]                tick_count_next;
  logic [1:0][RAMP_PH_W-1:0]  up_phase;
  logic [1:0][RAMP_PH_W-1:0]  up_phase_next;
  logic [1:0][RAMP_PH_W-1:0]  down_phase;
  logic [1:0][RAMP_PH_W-1:0]  down_phase_next;
  logic [LED_PH_W-1:0]        led_phase;
  logic [LED_PH_W-1:0]        led_phase_next;
  logic [TOG_PH_W-1:0]        tog_phase;
  logic [TOG_PH_W-1:0]        tog_phase_next;
  logic                       drive_latched;
  logic                       drive_latched_next;
  logic [1:0][15:0]           freq_now;
  logic [1:0][15:0]           freq_now_next;
  logic [1:0][15:0]           goal_freq;
  logic [1:0][15:0]           goal_freq_next;
  logic [1:0][7:0]            step_count;
  logic [1:0][7:0]            step_count_next;
  logic [1:0]                 ramp_up;
  logic [1:0]                 ramp_up_next;
  logic [1:0]                 ramp_down;
  logic [1:0]                 ramp_down_next;
  logic [1:0]                 changed;
  logic                       led_state;
  logic                       led_state_next;
  logic [4:0]                 beacon_count;
  logic [4:0]                 beacon_count_next;
  logic                       beacon_now;
  logic                       motor_enable;
  logic                       motor_enable_next;

  logic        s_fire;
  op_t         op;
  logic        motor;
  logic [15:0] target_freq;
  logic        status_acked;
  logic        is_tick;
  logic        cfg_write;
  reg_idx_t    cfg_idx;

  // Beat fields and handshake.
  assign op            = op_t'(s_axis_tuser[1:0]);
  assign motor         = s_axis_tuser[2];
  assign target_freq   = s_axis_tdata[15:0];
  assign status_acked  = s_axis_tdata[16];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (op == OP_TICK);

  // Register file writes and reads.
  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_step    <= {2{16'd100}};
      down_step  <= {2{16'd100}};
      step_limit <= {2{8'd20}};
      floor_freq <= {2{16'd100}};
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_UP_STEP_A:    up_step[0]    <= pwdata[15:0];
        REG_DOWN_STEP_A:  down_step[0]  <= pwdata[15:0];
        REG_UP_STEP_B:    up_step[1]    <= pwdata[15:0];
        REG_DOWN_STEP_B:  down_step[1]  <= pwdata[15:0];
        REG_STEP_LIMIT_A: step_limit[0] <= pwdata[7:0];
        REG_STEP_LIMIT_B: step_limit[1] <= pwdata[7:0];
        REG_FLOOR_FREQ_A: floor_freq[0] <= pwdata[15:0];
        REG_FLOOR_FREQ_B: floor_freq[1] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_UP_STEP_A:    prdata = {16'd0, up_step[0]};
      REG_DOWN_STEP_A:  prdata = {16'd0, down_step[0]};
      REG_UP_STEP_B:    prdata = {16'd0, up_step[1]};
      REG_DOWN_STEP_B:  prdata = {16'd0, down_step[1]};
      REG_STEP_LIMIT_A: prdata = {24'd0, step_limit[0]};
      REG_STEP_LIMIT_B: prdata = {24'd0, step_limit[1]};
      REG_FLOOR_FREQ_A: prdata = {16'd0, floor_freq[0]};
      REG_FLOOR_FREQ_B: prdata = {16'd0, floor_freq[1]};
      default:          prdata = 32'd0;
    endcase
  end

  // Tick counter and phase counters; each phase is the tick count modulo its period,
  // and all phases restart when the tick counter wraps to zero.
  always_comb begin
    tick_count_next = tick_count;
    up_phase_next   = up_phase;
    down_phase_next = down_phase;
    led_phase_next  = led_phase;
    tog_phase_next  = tog_phase;
    if (is_tick) begin
      tick_count_next = tick_count + 16'd1;
      for (int m = 0; m < 2; m++) begin
        if (tick_count_next == 16'd0 || up_phase[m] == UP_PERIODS[m] - RAMP_PH_W'(1)) begin
          up_phase_next[m] = '0;
        end else begin
          up_phase_next[m] = up_phase[m] + RAMP_PH_W'(1);
        end
        if (tick_count_next == 16'd0 ||
            down_phase[m] == DOWN_PERIODS[m] - RAMP_PH_W'(1)) begin
          down_phase_next[m] = '0;
        end else begin
          down_phase_next[m] = down_phase[m] + RAMP_PH_W'(1);
        end
      end
      if (tick_count_next == 16'd0 || led_phase == LED_PH_W'(LED_PERIOD - 1)) begin
        led_phase_next = '0;
      end else begin
        led_phase_next = led_phase + LED_PH_W'(1);
      end
      if (tick_count_next == 16'd0 || tog_phase == TOG_PH_W'(TOGGLE_SPAN - 1)) begin
        tog_phase_next = '0;
      end else begin
        tog_phase_next = tog_phase + TOG_PH_W'(1);
      end
    end
  end

  // Ramp logic per motor: ramp-up step first, then ramp-down step, then commands.
  always_comb begin
    logic [16:0] sum;
    logic [15:0] f;
    logic [7:0]  s;
    logic        r;
    logic        d;
    for (int m = 0; m < 2; m++) begin
      f = freq_now[m];
      s = step_count[m];
      r = ramp_up[m];
      d = ramp_down[m];
      changed[m] = 1'b0;
      goal_freq_next[m] = goal_freq[m];
      sum = {1'b0, f} + {1'b0, up_step[m]};
      if (is_tick) begin
        if (r && s < step_limit[m] && up_phase_next[m] == '0) begin
          changed[m] = 1'b1;
          s = s + 8'd1;
          if (sum >= {1'b0, goal_freq[m]} || s >= step_limit[m]) begin
            f = goal_freq[m];
            r = 1'b0;
          end else begin
            f = sum[15:0];
          end
        end
        if (d && s != 8'd0 && down_phase_next[m] == '0) begin
          changed[m] = 1'b1;
          s = s - 8'd1;
          if (down_step[m] > f || f - down_step[m] < floor_freq[m]) begin
            f = floor_freq[m];
            d = 1'b0;
            s = 8'd0;
          end else begin
            f = f - down_step[m];
          end
        end
      end else if (op == OP_START && motor == m[0]) begin
        goal_freq_next[m] = target_freq;
        r = 1'b1;
        d = 1'b0;
      end else if (op == OP_STOP && motor == m[0]) begin
        r = 1'b0;
        d = 1'b1;
      end
      freq_now_next[m]   = f;
      step_count_next[m] = s;
      ramp_up_next[m]    = r;
      ramp_down_next[m]  = d;
    end
  end

  // Drive latch, LED, beacons and the motor-enable toggle.
  always_comb begin
    drive_latched_next = drive_latched;
    led_state_next     = led_state;
    beacon_count_next  = beacon_count;
    beacon_now         = 1'b0;
    motor_enable_next  = motor_enable;
    if (is_tick) begin
      if (tick_count_next >= 16'(ENABLE_DELAY)) begin
        drive_latched_next = 1'b1;
      end
      if (led_phase_next == '0) begin
        led_state_next = !led_state;
        if (!status_acked && beacon_count < 5'(BEACON_MAX)) begin
          beacon_now        = 1'b1;
          beacon_count_next = beacon_count + 5'd1;
        end
      end
      if (tog_phase_next == TOG_PH_W'(TOGGLE_PHASE)) begin
        motor_enable_next = !motor_enable;
      end
    end
  end

  // State registers, updated on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      up_phase      <= '0;
      down_phase    <= '0;
      led_phase     <= '0;
      tog_phase     <= '0;
      drive_latched <= 1'b0;
      freq_now      <= '0;
      goal_freq     <= '0;
      step_count    <= '0;
      ramp_up       <= '0;
      ramp_down     <= '0;
      led_state     <= 1'b0;
      beacon_count  <= '0;
      motor_enable  <= 1'b0;
    end else if (s_fire) begin
      tick_count    <= tick_count_next;
      up_phase      <= up_phase_next;
      down_phase    <= down_phase_next;
      led_phase     <= led_phase_next;
      tog_phase     <= tog_phase_next;
      drive_latched <= drive_latched_next;
      freq_now      <= freq_now_next;
      goal_freq     <= goal_freq_next;
      step_count    <= step_count_next;
      ramp_up       <= ramp_up_next;
      ramp_down     <= ramp_down_next;
      led_state     <= led_state_next;
      beacon_count  <= beacon_count_next;
      motor_enable  <= motor_enable_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_axis_tdata <= {6'd0, motor_enable_next, beacon_now, led_state_next,
                       drive_latched_next, ramp_down_next[1], ramp_up_next[1],
                       ramp_down_next[0], ramp_up_next[0], changed[1], changed[0],
                       freq_now_next[1], freq_now_next[0]};
    end
  end

`ifndef NO_ASSERTIONS
  // A motor never ramps up and down at once.
  a_ramp_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ramp_up[0] && ramp_down[0]) && !(ramp_up[1] && ramp_down[1]))
    else $error("ramp-up and ramp-down armed together");

  // Beacon count never passes its maximum.
  a_beacon_max: assert property (@(posedge clk) disable iff (rst)
    beacon_count <= 5'(BEACON_MAX))
    else $error("beacon count above maximum");

  // Drive enable, once latched, stays latched.
  a_drive_sticky: assert property (@(posedge clk) disable iff (rst)
    drive_latched |=> drive_latched)
    else $error("drive enable dropped");

  // Commands do not advance the tick counter.
  a_cmd_no_tick: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !is_tick) |=> $stable(tick_count))
    else $error("tick counter moved on a command beat");

  // An empty output register never blocks the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");
`endif

endmodule

[tb/ramp_checker.sv]
// Checker for the dual stepper frequency ramp: tracks registers, predicts and compares status beats.
module ramp_checker
  import dsfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic [S_USER_W-1:0] s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  outstanding,
  output int                  beats_checked
);

  // Status beat layout, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic        enable_toggle;
    logic        beacon;
    logic        led_lit;
    logic        drive_on;
    logic        falling_b;
    logic        rising_b;
    logic        falling_a;
    logic        rising_a;
    logic        update_b;
    logic        update_a;
    logic [15:0] freq_b;
    logic [15:0] freq_a;
  } status_t;

  // Register copies, motor A at index 0.
  logic [15:0] up_step    [2];
  logic [15:0] down_step  [2];
  logic [7:0]  step_limit [2];
  logic [15:0] floor_freq [2];

  // Tick engine and ramp state.
  logic [15:0] ticks;
  logic        drive_latched;
  logic [15:0] freq_now    [2];
  logic [15:0] goal_freq   [2];
  logic [7:0]  steps_taken [2];
  logic        ramp_up     [2];
  logic        ramp_down   [2];
  logic        led_on;
  logic [4:0]  beacons_sent;
  logic        enable_flag;

  status_t due_status [$];

  // One tick of ramp work for one motor; returns whether its frequency was stepped.
  function automatic logic step_motor(input int m, input int up_p, input int down_p);
    logic        changed;
    logic [16:0] sum;
    changed = 1'b0;
    if (ramp_up[m] && steps_taken[m] < step_limit[m] && ticks % up_p == 0) begin
      sum = {1'b0, freq_now[m]} + {1'b0, up_step[m]};
      steps_taken[m] = steps_taken[m] + 8'd1;
      changed = 1'b1;
      if (sum >= {1'b0, goal_freq[m]} || steps_taken[m] >= step_limit[m]) begin
        freq_now[m] = goal_freq[m];
        ramp_up[m] = 1'b0;
      end else begin
        freq_now[m] = sum[15:0];
      end
    end
    // Ramp-down clamps at the floor instead of wrapping below zero.
    if (ramp_down[m] && steps_taken[m] != 8'd0 && ticks % down_p == 0) begin
      changed = 1'b1;
      steps_taken[m] = steps_taken[m] - 8'd1;
      if (down_step[m] > freq_now[m] || freq_now[m] - down_step[m] < floor_freq[m]) begin
        freq_now[m] = floor_freq[m];
        ramp_down[m] = 1'b0;
        steps_taken[m] = 8'd0;
      end else begin
        freq_now[m] = freq_now[m] - down_step[m];
      end
    end
    return changed;
  endfunction

  // Applies one input beat to the state and returns the status it should produce.
  function automatic status_t predict_status(input op_t op, input logic motor,
                                             input logic [15:0] target, input logic acked);
    status_t s;
    s = '0;
    case (op)
      OP_TICK: begin
        ticks = ticks + 16'd1;
        if (ticks >= ENABLE_DELAY) drive_latched = 1'b1;
        s.update_a = step_motor(0, UP_PERIOD_A, DOWN_PERIOD_A);
        s.update_b = step_motor(1, UP_PERIOD_B, DOWN_PERIOD_B);
        if (ticks % LED_PERIOD == 0) begin
          if (!acked && beacons_sent < BEACON_MAX) begin
            s.beacon = 1'b1;
            beacons_sent = beacons_sent + 5'd1;
          end
          led_on = !led_on;
        end
        if (ticks % TOGGLE_SPAN == TOGGLE_PHASE) enable_flag = !enable_flag;
      end
      OP_START: begin
        goal_freq[motor] = target;
        ramp_up[motor] = 1'b1;
        ramp_down[motor] = 1'b0;
      end
      OP_STOP: begin
        ramp_down[motor] = 1'b1;
        ramp_up[motor] = 1'b0;
      end
      default: ;
    endcase
    s.freq_a        = freq_now[0];
    s.freq_b        = freq_now[1];
    s.rising_a      = ramp_up[0];
    s.falling_a     = ramp_down[0];
    s.rising_b      = ramp_up[1];
    s.falling_b     = ramp_down[1];
    s.drive_on      = drive_latched;
    s.led_lit       = led_on;
    s.enable_toggle = enable_flag;
    return s;
  endfunction

  // Value a register read should return, zero-extended.
  function automatic logic [31:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_UP_STEP_A:    return {16'd0, up_step[0]};
      REG_DOWN_STEP_A:  return {16'd0, down_step[0]};
      REG_UP_STEP_B:    return {16'd0, up_step[1]};
      REG_DOWN_STEP_B:  return {16'd0, down_step[1]};
      REG_STEP_LIMIT_A: return {24'd0, step_limit[0]};
      REG_STEP_LIMIT_B: return {24'd0, step_limit[1]};
      REG_FLOOR_FREQ_A: return {16'd0, floor_freq[0]};
      default:          return {16'd0, floor_freq[1]};
    endcase
  endfunction

  // Compares one status beat with the oldest prediction, naming every wrong field.
  task automatic compare_status(input status_t got);
    status_t want;
    string   diff;
    beats_checked = beats_checked + 1;
    if (due_status.size() == 0) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10)
        $display("status beat %0d arrived with nothing predicted: %h", beats_checked, got);
    end else begin
      want = due_status.pop_front();
      diff = "";
      if (got.freq_a !== want.freq_a)               diff = {diff, " freq_a"};
      if (got.freq_b !== want.freq_b)               diff = {diff, " freq_b"};
      if (got.update_a !== want.update_a)           diff = {diff, " update_a"};
      if (got.update_b !== want.update_b)           diff = {diff, " update_b"};
      if (got.rising_a !== want.rising_a)           diff = {diff, " rising_a"};
      if (got.falling_a !== want.falling_a)         diff = {diff, " falling_a"};
      if (got.rising_b !== want.rising_b)           diff = {diff, " rising_b"};
      if (got.falling_b !== want.falling_b)         diff = {diff, " falling_b"};
      if (got.drive_on !== want.drive_on)           diff = {diff, " drive_on"};
      if (got.led_lit !== want.led_lit)             diff = {diff, " led_lit"};
      if (got.beacon !== want.beacon)               diff = {diff, " beacon"};
      if (got.enable_toggle !== want.enable_toggle) diff = {diff, " enable_toggle"};
      if (got.pad !== want.pad)                     diff = {diff, " padding"};
      if (diff != "") begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("status beat %0d wrong in%s: expected %h, got %h",
                   beats_checked, diff, want, got);
      end
    end
  endtask

  // Watch all three channels; outputs and inputs are sampled as they stood before the edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < 2; m++) begin
        up_step[m]     = 16'd100;
        down_step[m]   = 16'd100;
        step_limit[m]  = 8'd20;
        floor_freq[m]  = 16'd100;
        freq_now[m]    = 16'd0;
        goal_freq[m]   = 16'd0;
        steps_taken[m] = 8'd0;
        ramp_up[m]     = 1'b0;
        ramp_down[m]   = 1'b0;
      end
      ticks         = 16'd0;
      drive_latched = 1'b0;
      led_on        = 1'b0;
      beacons_sent  = 5'd0;
      enable_flag   = 1'b0;
      due_status.delete();
      mismatches    = 0;
      outstanding   = 0;
      beats_checked = 0;
    end else begin
      // Register access.
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_UP_STEP_A:    up_step[0]    = pwdata[15:0];
            REG_DOWN_STEP_A:  down_step[0]  = pwdata[15:0];
            REG_UP_STEP_B:    up_step[1]    = pwdata[15:0];
            REG_DOWN_STEP_B:  down_step[1]  = pwdata[15:0];
            REG_STEP_LIMIT_A: step_limit[0] = pwdata[7:0];
            REG_STEP_LIMIT_B: step_limit[1] = pwdata[7:0];
            REG_FLOOR_FREQ_A: floor_freq[0] = pwdata[15:0];
            REG_FLOOR_FREQ_B: floor_freq[1] = pwdata[15:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(reg_idx_t'(paddr[ADDR_W-1:2]))) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("register read at %h: expected %h, got %h",
                     paddr, reg_value(reg_idx_t'(paddr[ADDR_W-1:2])), prdata);
        end
      end
      // Result beat first: a beat accepted at this edge cannot also leave at it.
      if (m_axis_tvalid && m_axis_tready) compare_status(status_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready)
        due_status.push_back(predict_status(op_t'(s_axis_tuser[1:0]), s_axis_tuser[2],
                                            s_axis_tdata[15:0], s_axis_tdata[16]));
      outstanding = due_status.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the dual stepper frequency ramp: stimulus, register setup and verdict.
module tb;
  import dsfr_pkg::*;

  typedef enum {CFG_RESET, CFG_ZERO, CFG_FULL, CFG_FINE, CFG_RANDOM} cfg_kind_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [15:0] target_freq, [16] status_acked, [23:17] zero
  logic [S_DATA_W-1:0] s_axis_tdata;
  // [1:0] op, [2] motor
  logic [S_USER_W-1:0] s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [15:0] freq_a, [31:16] freq_b, [32] update_a, [33] update_b, [34] rising_a,
  // [35] falling_a, [36] rising_b, [37] falling_b, [38] drive_on, [39] led_lit,
  // [40] beacon, [41] enable_toggle, [47:42] zero
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int errors;
  int pending;
  int beats_seen;
  int settings_done;
  int stall_left;
  bit tx_idle;
  bit rx_idle;

  dual_stepper_frequency_ramp_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ramp_checker status_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(errors), .outstanding(pending), .beats_checked(beats_seen)
  );

  // Clock, period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: after each beat, hold tready low for a random stall if rx_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall_left = rx_idle ? $urandom_range(0, 11) : 0;
      m_axis_tready <= (stall_left == 0);
    end else if (!m_axis_tready) begin
      if (stall_left > 0) stall_left = stall_left - 1;
      m_axis_tready <= (stall_left == 0);
    end
  end

  // One APB transfer: setup cycle, access cycle, then an idle cycle.
  task automatic reg_access(input reg_idx_t idx, input logic write, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes every register for one setting and reads each back.
  task automatic apply_setting(input cfg_kind_t kind);
    logic [15:0] vals [8];
    case (kind)
      CFG_RESET: begin
        vals[REG_UP_STEP_A] = 16'd100;    vals[REG_DOWN_STEP_A] = 16'd100;
        vals[REG_UP_STEP_B] = 16'd100;    vals[REG_DOWN_STEP_B] = 16'd100;
        vals[REG_STEP_LIMIT_A] = 16'd20;  vals[REG_STEP_LIMIT_B] = 16'd20;
        vals[REG_FLOOR_FREQ_A] = 16'd100; vals[REG_FLOOR_FREQ_B] = 16'd100;
      end
      CFG_ZERO: begin
        foreach (vals[i]) vals[i] = 16'd0;
      end
      CFG_FULL: begin
        foreach (vals[i]) vals[i] = 16'hFFFF;
        vals[REG_STEP_LIMIT_A] = 16'd255;
        vals[REG_STEP_LIMIT_B] = 16'd255;
      end
      CFG_FINE: begin
        // Small steps with a long limit on A and a single step on B.
        vals[REG_UP_STEP_A] = 16'($urandom_range(1, 60));
        vals[REG_DOWN_STEP_A] = 16'($urandom_range(1, 60));
        vals[REG_UP_STEP_B] = 16'($urandom_range(1, 600));
        vals[REG_DOWN_STEP_B] = 16'($urandom_range(1, 600));
        vals[REG_STEP_LIMIT_A] = 16'd255;
        vals[REG_STEP_LIMIT_B] = 16'd1;
        vals[REG_FLOOR_FREQ_A] = 16'd0;
        vals[REG_FLOOR_FREQ_B] = 16'($urandom_range(0, 300));
      end
      default: begin
        vals[REG_UP_STEP_A] = 16'($urandom_range(0, 65535));
        vals[REG_DOWN_STEP_A] = 16'($urandom_range(0, 2000));
        vals[REG_UP_STEP_B] = 16'($urandom_range(0, 2000));
        vals[REG_DOWN_STEP_B] = 16'($urandom_range(0, 65535));
        vals[REG_STEP_LIMIT_A] = 16'($urandom_range(0, 255));
        vals[REG_STEP_LIMIT_B] = 16'($urandom_range(0, 40));
        vals[REG_FLOOR_FREQ_A] = 16'($urandom_range(0, 65535));
        vals[REG_FLOOR_FREQ_B] = 16'($urandom_range(0, 1000));
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      reg_access(reg_idx_t'(i), 1'b1, {16'd0, vals[i]});
      reg_access(reg_idx_t'(i), 1'b0, 32'd0);
    end
    settings_done = settings_done + 1;
  endtask

  // Sends one beat after a random gap (only if tx_idle); tvalid is left high once taken.
  task automatic send_beat(input op_t op, input logic motor, input logic [15:0] target,
                           input logic acked);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {motor, op};
    s_axis_tdata  <= {7'd0, acked, target};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops sending and waits until every predicted status beat has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed cases: unused op, stop with no steps taken, extreme goals, one ramp each way.
  task automatic directed_ramps();
    send_beat(OP_NONE, 1'b1, 16'hFFFF, 1'b1);
    send_beat(OP_STOP, 1'b0, 16'h0000, 1'b0);
    send_beat(OP_START, 1'b0, 16'hFFFF, 1'b0);
    send_beat(OP_START, 1'b1, 16'h0000, 1'b1);
    for (int i = 0; i < 10; i++)
      send_beat(OP_TICK, i[0], i[0] ? 16'hFFFF : 16'h0000, i[1]);
    send_beat(OP_STOP, 1'b0, 16'h5555, 1'b1);
    send_beat(OP_STOP, 1'b1, 16'hAAAA, 1'b0);
    for (int i = 0; i < 10; i++)
      send_beat(OP_TICK, i[1], i[0] ? 16'hAAAA : 16'h5555, i[0]);
  endtask

  // Mostly ticks with starts and stops mixed in; goals lean small so ramps finish.
  task automatic random_ramps(input int count);
    int          done;
    int          r;
    op_t         op;
    logic [15:0] target;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 39) == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      r = $urandom_range(0, 99);
      op = r < 72 ? OP_TICK : r < 84 ? OP_START : r < 95 ? OP_STOP : OP_NONE;
      case ($urandom_range(0, 3))
        0:       target = 16'($urandom_range(0, 65535));
        1:       target = 16'($urandom_range(0, 2500));
        2:       target = 16'hFFFF;
        default: target = 16'($urandom_range(0, 600));
      endcase
      send_beat(op, 1'($urandom_range(0, 1)), target, $urandom_range(0, 3) == 0);
      if (op != OP_NONE) done = done + 1;
      // Now and then let everything settle before carrying on.
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  // A burst of beats, mostly ticks, with no idle cycles on either side.
  task automatic long_tick_run(input int count);
    int r;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 97)
        send_beat(OP_TICK, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                  $urandom_range(0, 7) == 0);
      else
        send_beat(r < 99 ? OP_START : OP_STOP, 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 3000)), 1'b0);
    end
  endtask

  // Main sequence.
  initial begin
    cfg_kind_t phase_kind [5];
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    settings_done = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    phase_kind = '{CFG_ZERO, CFG_FULL, CFG_FINE, CFG_RANDOM, CFG_RANDOM};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_setting(CFG_RESET);
    directed_ramps();
    drain();

    foreach (phase_kind[p]) begin
      apply_setting(phase_kind[p]);
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      random_ramps(130);
      drain();
    end

    apply_setting(CFG_FINE);
    long_tick_run(40);
    drain();

    $display("checked %0d status beats under %0d register settings", beats_seen,
             settings_done);
    $display("including random stalls on both sides and a burst with no idle cycles");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[dual_stepper_frequency_ramp_top.f]
rtl/dsfr_pkg.sv
rtl/dual_stepper_frequency_ramp_top.sv
tb/ramp_checker.sv
tb/tb.sv
